>>> src/bitmap_find_next_bit_core_defines.svh
// assertion macros for the bitmap next-bit search core
// each macro expects clk and rst in scope
`ifndef BITMAP_FIND_NEXT_BIT_CORE_DEFINES_SVH
`define BITMAP_FIND_NEXT_BIT_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BFNB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BFNB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bfnb_pkg.sv
// ---------------------------------------------------------------------------
// bfnb_pkg
// Types, constants and helpers shared by the bitmap next-bit search core.
// ---------------------------------------------------------------------------
package bfnb_pkg;

  // fixed field widths
  localparam int POS_W     = 13;
  localparam int WIDX_W    = 6;
  localparam int WDATA_W   = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;

  // parameter defaults
  localparam int NUM_WORDS_DEF = 64;
  localparam int WORD_BITS_DEF = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BITS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_BITS = 1'b1;

  // register reset values
  localparam logic [POS_W-1:0] SIZE_RESET = 13'd4096;

  // item modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [WIDX_W-1:0]    word_index;
    logic [WDATA_W-1:0]   word_data;
    logic [POS_W-1:0]     start_position;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] found_position;
    logic             found;
  } out_item_t;

  // trailing zero count by halving, word must be non-zero
  function automatic logic [5:0] ctz64(input logic [63:0] w);
    logic [63:0] v;
    logic [5:0]  n;
    v = w;
    n = '0;
    if (v[31:0] == 32'h0000_0000) begin
      n = n + 6'd32;
      v = v >> 32;
    end
    if (v[15:0] == 16'h0000) begin
      n = n + 6'd16;
      v = v >> 16;
    end
    if (v[7:0] == 8'h00) begin
      n = n + 6'd8;
      v = v >> 8;
    end
    if (v[3:0] == 4'h0) begin
      n = n + 6'd4;
      v = v >> 4;
    end
    if (v[1:0] == 2'b00) begin
      n = n + 6'd2;
      v = v >> 2;
    end
    if (v[0] == 1'b0) begin
      n = n + 6'd1;
    end
    return n;
  endfunction

endpackage

>>> src/bitmap_find_next_bit_core.sv
// ---------------------------------------------------------------------------
// bitmap_find_next_bit_core
// Bitmap of NUM_WORDS words held in a synchronous memory, with word writes
// and a find-next-set (or next-clear) bit search from a start position.
// ---------------------------------------------------------------------------
// After reset the block clears every word of the bitmap memory in turn
// and accepts no item meanwhile (configuration writes are taken). A write
// item is written to memory as it is accepted. A search item steps through
// the divide, address and read states, staying in read for each word walked
// (at least one), since the single memory read port delivers one word per
// cycle; a search whose start is at or past the limit goes straight to the
// done state. The next item is accepted once the result sits in the output
// register, which holds it until taken.
module bitmap_find_next_bit_core #(
  parameter int NUM_WORDS = bfnb_pkg::NUM_WORDS_DEF,
  parameter int WORD_BITS = bfnb_pkg::WORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bfnb_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bfnb_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [bfnb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfnb_pkg::CFG_W-1:0]        cfg_data
);
  import bfnb_pkg::*;

  `include "bitmap_find_next_bit_core_defines.svh"

  localparam int IDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int REM_W    = $clog2(WORD_BITS);
  localparam int SUM_W    = POS_W + 1;
  localparam int TOTAL    = NUM_WORDS * WORD_BITS;
  // start / WORD_BITS by reciprocal, exact for every 13-bit start
  localparam int DIV_K    = POS_W + 7;
  localparam int RECIP    = ((1 << DIV_K) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PROD_W   = POS_W + RECIP_W;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]           state;
  logic [IDX_W-1:0]     clr_idx;
  logic [POS_W-1:0]     size_bits;
  logic                 invert_bits;
  logic [POS_W-1:0]     eff_size;
  logic [POS_W-1:0]     sz_r;
  logic [POS_W-1:0]     start_r;
  logic [IDX_W-1:0]     idx;
  logic [SUM_W-1:0]     base;
  logic [REM_W-1:0]     rem_r;
  logic                 first;
  logic [POS_W-1:0]     res_pos;
  logic                 res_found;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     rd_addr;
  logic                 rd_en;
  logic                 mem_we;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic                 accept;
  logic [PROD_W-1:0]    quot_prod;
  logic [SUM_W-1:0]     idx_base;
  logic [WORD_BITS-1:0] word_cur;
  logic [WORD_BITS-1:0] first_mask;
  logic [WORD_BITS-1:0] tmp;
  logic                 hit;
  logic [SUM_W-1:0]     next_base;
  logic                 last_word;
  logic [SUM_W-1:0]     hit_pos;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);

  // effective limit, never past the bitmap
  assign eff_size = (32'(size_bits) < TOTAL) ? size_bits : POS_W'(TOTAL);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits   <= SIZE_RESET;
      invert_bits <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_BITS:   size_bits   <= cfg_data[POS_W-1:0];
        CFG_INVERT_BITS: invert_bits <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // memory write side: clearing pass, then word writes
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_idx;
    wr_data = '0;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (accept && in_item.mode == MODE_WRITE &&
                 32'(in_item.word_index) < NUM_WORDS) begin
      mem_we  = 1'b1;
      wr_addr = IDX_W'(in_item.word_index);
      wr_data = in_item.word_data[WORD_BITS-1:0];
    end
  end

  // search datapath on the word just read
  assign quot_prod  = PROD_W'(start_r) * PROD_W'(RECIP);
  assign idx_base   = SUM_W'(idx) * SUM_W'(WORD_BITS);
  assign word_cur   = rd_data ^ {WORD_BITS{invert_bits}};
  assign first_mask = {WORD_BITS{1'b1}} << rem_r;
  assign tmp        = first ? (word_cur & first_mask) : word_cur;
  assign hit        = (tmp != '0);
  assign next_base  = base + SUM_W'(WORD_BITS);
  assign last_word  = (next_base >= SUM_W'(sz_r));
  assign hit_pos    = base + SUM_W'(ctz64(64'(tmp)));

  // memory read side: one word a cycle while walking
  always_comb begin
    rd_addr = idx;
    rd_en   = 1'b0;
    if (state == ST_ADDR) begin
      rd_en = 1'b1;
    end else if (state == ST_READ && !hit && !last_word) begin
      rd_en   = 1'b1;
      rd_addr = idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_idx == IDX_W'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
          clr_idx <= clr_idx + IDX_W'(1);
        end
        ST_IDLE: begin
          if (accept && in_item.mode == MODE_SEARCH) begin
            if (in_item.start_position < eff_size) begin
              state <= ST_DIV;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DIV:  state <= ST_ADDR;
        ST_ADDR: state <= ST_READ;
        ST_READ: begin
          if (hit || last_word) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // search payload registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        start_r   <= in_item.start_position;
        sz_r      <= eff_size;
        res_pos   <= eff_size;
        res_found <= 1'b0;
      end
      ST_DIV: begin
        idx <= IDX_W'(quot_prod >> DIV_K);
      end
      ST_ADDR: begin
        base  <= idx_base;
        rem_r <= REM_W'(SUM_W'(start_r) - idx_base);
        first <= 1'b1;
      end
      ST_READ: begin
        if (hit) begin
          if (hit_pos > SUM_W'(sz_r)) begin
            res_pos <= sz_r;
          end else begin
            res_pos <= POS_W'(hit_pos);
          end
          res_found <= (hit_pos < SUM_W'(sz_r));
        end else if (!last_word) begin
          idx   <= idx + IDX_W'(1);
          base  <= next_base;
          first <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_item.found_position <= res_pos;
      out_item.found          <= res_found;
    end
  end

  // checks
  `BFNB_ASSERT_NOW(a_load_from_done, $rose(out_valid), $past(state) == ST_DONE, "result loaded outside done")
  `BFNB_ASSERT_NOW(a_walk_in_range, state == ST_READ, 32'(idx) < NUM_WORDS, "word walk past bitmap end")
  `BFNB_ASSERT_NOW(a_base_tracks_idx, state == ST_READ, 32'(base) == 32'(idx) * WORD_BITS, "base position out of step with word index")
  `BFNB_ASSERT_NOW(a_found_below_limit, state == ST_DONE && res_found, res_pos < sz_r, "found position not below limit")
  `BFNB_ASSERT_NEXT(a_no_accept_clear, state == ST_CLEAR && clr_idx != IDX_W'(NUM_WORDS - 1), state == ST_CLEAR, "clearing pass cut short")

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for bitmap_find_next_bit_core. Word writes and
// next-bit searches are pushed through the valid/ready input while the
// result side stalls on its own pattern. A scoreboard keeps a private copy
// of the bitmap and the two registers and predicts every search result.
// ---------------------------------------------------------------------------
module testbench;
  import bfnb_pkg::*;

  localparam int MAP_WORDS     = 64;
  localparam int MAP_BITS      = 64 * 64;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 200;
  localparam int PHASES        = 7;
  localparam int HOLD_CYCLES   = 400;

  // shadow bitmap, registers and queue of predicted search results
  class next_bit_scoreboard;
    logic [63:0] map_words [MAP_WORDS];
    int unsigned size_limit;
    bit          invert;
    out_item_t   pending_results [$];
    int          mismatch_count;

    function new();
      foreach (map_words[i]) map_words[i] = '0;
      size_limit     = 32'(SIZE_RESET);
      invert         = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_SIZE_BITS) size_limit = 32'(value);
      else if (idx == CFG_INVERT_BITS) invert = value[0];
    endfunction

    // word as the search sees it, flipped when looking for clear bits
    function logic [63:0] search_word(int unsigned idx);
      logic [63:0] w;
      w = map_words[idx];
      if (invert) w = ~w;
      return w;
    endfunction

    function int unsigned lowest_set(logic [63:0] w);
      int unsigned n;
      n = 0;
      while (n < 64 && !w[n]) n++;
      return n;
    endfunction

    // walk upward from the start word, clamp the hit to the limit
    function out_item_t next_match(logic [POS_W-1:0] start);
      out_item_t   res;
      int unsigned limit;
      int unsigned pos;
      int unsigned idx;
      logic [63:0] w;
      limit = (size_limit < MAP_BITS) ? size_limit : MAP_BITS;
      pos   = limit;
      if (start < limit) begin
        idx = start / 64;
        w   = search_word(idx) & ({64{1'b1}} << (start % 64));
        while (w == '0 && (idx + 1) * 64 < limit) begin
          idx++;
          w = search_word(idx);
        end
        if (w != '0) begin
          pos = idx * 64 + lowest_set(w);
          if (pos > limit) pos = limit;
        end
      end
      res.found_position = POS_W'(pos);
      res.found          = (pos < limit);
      return res;
    endfunction

    function void note_item(in_item_t item);
      if (item.mode == MODE_WRITE) map_words[item.word_index] = item.word_data;
      else pending_results.push_back(next_match(item.start_position));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatch_count++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result position %0d found %0b with no search waiting",
                         got.found_position, got.found));
        return;
      end
      want = pending_results.pop_front();
      if (got.found_position !== want.found_position)
        report($sformatf("found_position got %0d want %0d",
                         got.found_position, want.found_position));
      if (got.found !== want.found)
        report($sformatf("found got %0b want %0b (position %0d)",
                         got.found, want.found, want.found_position));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  next_bit_scoreboard sb = new();

  bitmap_find_next_bit_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock and reset
  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // note accepted items and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  // watchdog on cycles with no handshake
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // result side: segments of different stall styles, two long hold-offs
  initial begin
    int seg;
    int seg_len;
    int style;
    int tick;
    out_ready = 1'b0;
    seg = 0;
    tick = 0;
    while (rst) @(negedge clk);
    forever begin
      if (seg == 6 || seg == 45) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        style   = $urandom_range(0, 3);
        seg_len = $urandom_range(20, 150);
        repeat (seg_len) begin
          @(negedge clk);
          tick++;
          case (style)
            0: out_ready = 1'b1;
            1: out_ready = 1'($urandom_range(0, 1));
            2: out_ready = (tick % 5) < 2;
            default: out_ready = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
      seg++;
    end
  end

  // input side
  task automatic offer_item(in_item_t item);
    @(negedge clk);
    in_item  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic hold_sender(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic in_item_t write_item(logic [WIDX_W-1:0] idx, logic [63:0] data);
    in_item_t item;
    item.mode           = MODE_WRITE;
    item.word_index     = idx;
    item.word_data      = data;
    item.start_position = POS_W'($urandom_range(0, 8191));
    return item;
  endfunction

  function automatic in_item_t search_item(int unsigned start);
    in_item_t item;
    item.mode           = MODE_SEARCH;
    item.word_index     = WIDX_W'($urandom_range(0, 63));
    item.word_data      = {$urandom, $urandom};
    item.start_position = POS_W'(start);
    return item;
  endfunction

  // about half background words so searches walk far, the rest single bits, random or full words
  function automatic logic [63:0] random_word(bit inv);
    logic [63:0] bg;
    int          pick;
    bg   = inv ? '1 : '0;
    pick = $urandom_range(0, 19);
    if (pick < 9) return bg;
    if (pick < 13) return bg ^ (64'd1 << $urandom_range(0, 63));
    if (pick < 16) return {$urandom, $urandom};
    return ~bg;
  endfunction

  // registers, written only while the block is idle; the caller keeps to that, this task does not enforce it
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic configure(int unsigned size, bit inv);
    write_register(CFG_SIZE_BITS, CFG_W'(size));
    write_register(CFG_INVERT_BITS, CFG_W'(inv));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop offering, wait for every result, let a trailing write settle
  task automatic drain;
    hold_sender(1);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    int unsigned phase_size [PHASES] = '{4096, 64, 8191, 65, 1, 4095, 0};
    int unsigned size;
    int unsigned eff;
    int unsigned start;
    int          burst_left;
    bit          inv;

    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SIZE_BITS;
    cfg_data  = '0;
    while (rst) @(posedge clk);

    // empty map, last bit, limits, out-of-range start, full and empty words
    configure(4096, 1'b0);
    offer_item(search_item(0));
    offer_item(write_item(6'd63, 64'h8000_0000_0000_0000));
    offer_item(search_item(0));
    offer_item(search_item(4095));
    offer_item(search_item(4096));
    offer_item(search_item(8191));
    offer_item(write_item(6'd0, '1));
    offer_item(search_item(0));
    offer_item(search_item(63));
    offer_item(search_item(64));
    offer_item(write_item(6'd0, '0));
    offer_item(write_item(6'd1, 64'd1 << 5));
    offer_item(search_item(3));
    drain();

    // clear-bit search with a limit beyond the map
    configure(8191, 1'b1);
    offer_item(search_item(0));
    offer_item(search_item(69));
    offer_item(write_item(6'd63, '1));
    offer_item(search_item(4032));
    drain();

    // hit in the last word past the limit is clamped
    configure(100, 1'b0);
    offer_item(write_item(6'd1, 64'd1 << 40));
    offer_item(search_item(0));
    offer_item(search_item(99));
    offer_item(search_item(100));
    drain();

    // zero and one bit limits
    configure(0, 1'b0);
    offer_item(search_item(0));
    drain();
    configure(1, 1'b0);
    offer_item(write_item(6'd0, 64'd1));
    offer_item(search_item(0));
    drain();

    // random phases, one register setting each
    for (int p = 0; p < PHASES; p++) begin
      size = (p == PHASES - 1) ? $urandom_range(0, 8191) : phase_size[p];
      inv  = (p == PHASES - 1) ? 1'($urandom_range(0, 1)) : 1'(p % 2);
      configure(size, inv);
      eff = (size < MAP_BITS) ? size : MAP_BITS;
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) hold_sender($urandom_range(1, 12));
          burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        if ($urandom_range(0, 9) < 4) begin
          offer_item(write_item(WIDX_W'($urandom_range(0, 63)), random_word(inv)));
        end else begin
          start = ($urandom_range(0, 3) != 0) ? $urandom_range(0, eff)
                                             : $urandom_range(0, 8191);
          offer_item(search_item(start));
        end
      end
      drain();
    end

    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
